// ===== hdl/sliding_window_sender_assert.svh =====
// assertion macros shared by the checker of the window sender
// depends on nothing
`ifndef SLIDING_WINDOW_SENDER_ASSERT_SVH
`define SLIDING_WINDOW_SENDER_ASSERT_SVH
// same-cycle implication, quiet during reset
`define SWSND_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication, quiet during reset
`define SWSND_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ===== hdl/swsnd_pkg.sv =====
// types and codes of the sliding window sender
// depends on nothing
`timescale 1ns / 1ps
package swsnd_pkg;
   localparam logic [1:0] OP_FILL    = 2'd0;
   localparam logic [1:0] OP_PACKET  = 2'd1;
   localparam logic [1:0] OP_TIMEOUT = 2'd2;

   localparam logic [1:0] KIND_NEW    = 2'd0;
   localparam logic [1:0] KIND_RESEND = 2'd1;
   localparam logic [1:0] KIND_STATUS = 2'd2;

   localparam logic [7:0] ACK_KIND = 8'd2;

   localparam logic [1:0] CSR_MODE    = 2'd0;
   localparam logic [1:0] CSR_TOTAL   = 2'd1;
   localparam logic [1:0] CSR_WINDOW  = 2'd2;
   localparam logic [1:0] CSR_TIMEOUT = 2'd3;

   localparam logic [30:0] RESET_TOTAL   = 31'd100000;
   localparam logic [6:0]  RESET_WINDOW  = 7'd8;
   localparam logic [31:0] RESET_TIMEOUT = 32'd100000;
   localparam logic [47:0] RTT_MAX       = 48'hFFFF_FFFF_FFFF;

   typedef struct packed {
      logic        acked;
      logic [31:0] send_time;
   } slot_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_FILL, ST_ACK_RD, ST_ACK_EX, ST_SLIDE_RD, ST_SLIDE_EX,
      ST_CUM_RD, ST_CUM_EX, ST_DROP_RD, ST_DROP_EX, ST_HEAD_RD, ST_HEAD_EX,
      ST_RS_RD, ST_RS_EX, ST_EMIT_RD, ST_EMIT_LD
   } state_type;
endpackage

// ===== hdl/sliding_window_sender.sv =====
// top level of the sliding window sender: sequencer, counters, csrs
// depends on swsnd_pkg, swsnd_slot_mem, swsnd_run_buf
//
// usage
//   req_ channel: one request per operation (fill, packet received,
//   timeout check). req_stall is high while a request is in work.
//   rsp_ channel: one result per sent or resent packet, or one status
//   result; rsp_last_of_run marks the final result of a request. All
//   counters in a result show the state after the whole request.
//   csr_ channel: register writes; the user must make them while the block is idle (unchecked).
// sequencing
//   every slot visit is a memory read, then an update; a fill
//   writes one slot per cycle. After the work, each result is a
//   buffer read, then an output load. Slots visited and results
//   are each bounded by the window depth.
// reset
//   synchronous; clears sequence numbers, counters and handshakes,
//   loads register defaults. Slot memory is not cleared.
// stall
//   the output register holds while rsp_stall is high; a new request
//   is taken while the last result of the previous one still waits.
`timescale 1ns / 1ps
module sliding_window_sender #(
   parameter int WINDOW_DEPTH = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_operation,
   input  logic [31:0]        req_time_now,
   input  logic [7:0]         req_packet_kind,
   input  logic signed [31:0] req_echo_sequence,
   input  logic signed [31:0] req_ack_sequence,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_result_kind,
   output logic [30:0]        rsp_packet_sequence,
   output logic               rsp_last_of_run,
   output logic [30:0]        rsp_window_base,
   output logic [31:0]        rsp_sent_count,
   output logic [31:0]        rsp_acked_count,
   output logic [31:0]        rsp_resend_count,
   output logic [47:0]        rsp_rtt_total,
   output logic               rsp_finished,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data
);
   import swsnd_pkg::*;

   localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int CW = $clog2(WINDOW_DEPTH + 1);
   localparam logic [AW-1:0] SLOT_LAST = AW'(WINDOW_DEPTH - 1);
   localparam logic [6:0] DEPTH7 = 7'(WINDOW_DEPTH);
   localparam logic [7:0] DEPTH8 = 8'(WINDOW_DEPTH);

   function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
      return (s == SLOT_LAST) ? '0 : s + 1'b1;
   endfunction

   // configuration registers
   logic        mode_ff;
   logic [30:0] total_ff;
   logic [6:0]  limit_ff;
   logic [31:0] timeout_ff;

   // sender state
   state_type   state_ff, state_in;
   logic [30:0] base_ff, base_in, next_ff, next_in;
   logic [AW-1:0] base_slot_ff, base_slot_in, next_slot_ff, next_slot_in;
   logic [31:0] sent_ff, sent_in, acked_ff, acked_in, resend_ff, resend_in;
   logic [47:0] rtt_ff, rtt_in;

   // latched request and loop cursor
   logic [31:0] now_ff, now_in;
   logic [30:0] ack_ff, ack_in;
   logic [30:0] cur_ff, cur_in;
   logic [AW-1:0] cur_slot_ff, cur_slot_in;
   logic [1:0]  run_kind_ff, run_kind_in;
   logic [CW-1:0] count_ff, count_in, idx_ff, idx_in;

   // output register
   logic        out_valid_ff, out_valid_in;
   logic [1:0]  out_kind_ff, out_kind_in;
   logic [30:0] out_seq_ff, out_seq_in;
   logic        out_last_ff, out_last_in;
   logic [30:0] out_base_ff, out_base_in;
   logic [31:0] out_sent_ff, out_sent_in, out_acked_ff, out_acked_in;
   logic [31:0] out_resend_ff, out_resend_in;
   logic [47:0] out_rtt_ff, out_rtt_in;
   logic        out_fin_ff, out_fin_in;

   // memories
   logic     slot_we;
   slot_type slot_wdata, slot_rdata;
   logic     buf_we;
   logic [30:0] buf_wdata, buf_rdata;

   swsnd_slot_mem #(.DEPTH(WINDOW_DEPTH), .AW(AW)) u_slots (
      .clock(clock), .wr_en(slot_we), .wr_addr(cur_slot_ff),
      .wr_data(slot_wdata), .rd_addr(cur_slot_ff), .rd_data(slot_rdata)
   );

   swsnd_run_buf #(.DEPTH(WINDOW_DEPTH), .AW(AW)) u_run (
      .clock(clock), .wr_en(buf_we), .wr_addr(count_ff[AW-1:0]),
      .wr_data(buf_wdata), .rd_addr(idx_ff[AW-1:0]), .rd_data(buf_rdata)
   );

   // request decode helpers
   logic [31:0] echo_u, ackn_u;
   logic [6:0]  win, echo_off;
   logic [7:0]  echo_slot_sum;
   logic [AW-1:0] echo_slot;
   logic        echo_ok, ackn_ok;
   logic [31:0] age;
   logic [48:0] rtt_sum;
   logic [47:0] rtt_sat;
   logic        out_free;

   assign echo_u = req_echo_sequence;
   assign ackn_u = req_ack_sequence;
   assign win = (limit_ff < DEPTH7) ? limit_ff : DEPTH7;
   assign echo_ok = (echo_u < {1'b0, total_ff}) && (echo_u >= {1'b0, base_ff})
                    && (echo_u < {1'b0, next_ff});
   assign ackn_ok = (req_packet_kind == ACK_KIND) && (ackn_u >= {1'b0, base_ff})
                    && (ackn_u < {1'b0, total_ff}) && (ackn_u < {1'b0, next_ff});
   // slot of an outstanding echo: base slot plus offset from base, wrapped
   assign echo_off = echo_u[6:0] - base_ff[6:0];
   always_comb begin
      echo_slot_sum = 8'(base_slot_ff) + {1'b0, echo_off};
      if (echo_slot_sum >= DEPTH8) begin
         echo_slot_sum = echo_slot_sum - DEPTH8;
      end
   end
   assign echo_slot = echo_slot_sum[AW-1:0];

   assign age = now_ff - slot_rdata.send_time;
   assign rtt_sum = {1'b0, rtt_ff} + {17'd0, age};
   assign rtt_sat = rtt_sum[48] ? RTT_MAX : rtt_sum[47:0];
   assign out_free = !out_valid_ff || !rsp_stall;

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   always_comb begin
      state_in = state_ff;
      base_in = base_ff;           base_slot_in = base_slot_ff;
      next_in = next_ff;           next_slot_in = next_slot_ff;
      sent_in = sent_ff;           acked_in = acked_ff;
      resend_in = resend_ff;       rtt_in = rtt_ff;
      now_in = now_ff;             ack_in = ack_ff;
      cur_in = cur_ff;             cur_slot_in = cur_slot_ff;
      run_kind_in = run_kind_ff;   count_in = count_ff;
      idx_in = idx_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_kind_in = out_kind_ff;   out_seq_in = out_seq_ff;
      out_last_in = out_last_ff;   out_base_in = out_base_ff;
      out_sent_in = out_sent_ff;   out_acked_in = out_acked_ff;
      out_resend_in = out_resend_ff; out_rtt_in = out_rtt_ff;
      out_fin_in = out_fin_ff;
      slot_we = 1'b0;
      slot_wdata = slot_rdata;
      buf_we = 1'b0;
      buf_wdata = cur_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               now_in = req_time_now;
               ack_in = ackn_u[30:0];
               count_in = '0;
               idx_in = '0;
               cur_in = base_ff;
               cur_slot_in = base_slot_ff;
               run_kind_in = KIND_NEW;
               state_in = ST_EMIT_RD;
               unique case (req_operation)
                  OP_FILL: begin
                     cur_slot_in = next_slot_ff;
                     state_in = ST_FILL;
                  end
                  OP_PACKET: begin
                     if (!mode_ff) begin
                        if (echo_ok) begin
                           cur_in = echo_u[30:0];
                           cur_slot_in = echo_slot;
                           state_in = ST_ACK_RD;
                        end
                     end else if (ackn_ok) begin
                        state_in = ST_CUM_RD;
                     end
                  end
                  OP_TIMEOUT: begin
                     run_kind_in = KIND_RESEND;
                     if (!mode_ff) begin
                        state_in = ST_DROP_RD;
                     end else if (base_ff < next_ff) begin
                        state_in = ST_HEAD_RD;
                     end
                  end
                  default: state_in = ST_EMIT_RD;
               endcase
            end
         end
         ST_FILL: begin
            // one new packet per cycle while window and total allow
            if ((next_ff < total_ff) &&
                ({1'b0, next_ff} < {1'b0, base_ff} + {25'd0, win})) begin
               slot_we = 1'b1;
               slot_wdata.acked = 1'b0;
               slot_wdata.send_time = now_ff;
               buf_we = 1'b1;
               buf_wdata = next_ff;
               count_in = count_ff + 1'b1;
               sent_in = sent_ff + 1'b1;
               next_in = next_ff + 1'b1;
               next_slot_in = slot_inc(next_slot_ff);
               cur_slot_in = slot_inc(cur_slot_ff);
            end else begin
               state_in = ST_EMIT_RD;
            end
         end
         ST_ACK_RD: state_in = ST_ACK_EX;
         ST_ACK_EX: begin
            if (!slot_rdata.acked) begin
               slot_we = 1'b1;
               slot_wdata.acked = 1'b1;
               acked_in = acked_ff + 1'b1;
               rtt_in = rtt_sat;
               // point the slot read at the base before the slide walk
               cur_slot_in = base_slot_ff;
               state_in = ST_SLIDE_RD;
            end else begin
               state_in = ST_EMIT_RD;
            end
         end
         ST_SLIDE_RD: begin
            cur_slot_in = base_slot_ff;
            state_in = ST_EMIT_RD;
            if ((base_ff < total_ff) && (base_ff < next_ff)) begin
               state_in = ST_SLIDE_EX;
            end
         end
         ST_SLIDE_EX: begin
            if (slot_rdata.acked) begin
               base_in = base_ff + 1'b1;
               base_slot_in = slot_inc(base_slot_ff);
               cur_slot_in = slot_inc(base_slot_ff);
               state_in = ST_SLIDE_RD;
            end else begin
               state_in = ST_EMIT_RD;
            end
         end
         ST_CUM_RD: state_in = ST_CUM_EX;
         ST_CUM_EX: begin
            if (!slot_rdata.acked) begin
               slot_we = 1'b1;
               slot_wdata.acked = 1'b1;
               acked_in = acked_ff + 1'b1;
               rtt_in = rtt_sat;
            end
            if (cur_ff == ack_ff) begin
               base_in = ack_ff + 1'b1;
               base_slot_in = slot_inc(cur_slot_ff);
               state_in = ST_EMIT_RD;
            end else begin
               cur_in = cur_ff + 1'b1;
               cur_slot_in = slot_inc(cur_slot_ff);
               state_in = ST_CUM_RD;
            end
         end
         ST_DROP_RD: begin
            state_in = ST_EMIT_RD;
            if ((base_ff < total_ff) && (base_ff < next_ff)) begin
               state_in = ST_DROP_EX;
            end
         end
         ST_DROP_EX: begin
            // unacked head that is not yet old stops the drop walk
            if (!slot_rdata.acked && (age < timeout_ff)) begin
               state_in = ST_EMIT_RD;
            end else begin
               if (!slot_rdata.acked) begin
                  slot_we = 1'b1;
                  slot_wdata.acked = 1'b1;
               end
               base_in = base_ff + 1'b1;
               base_slot_in = slot_inc(base_slot_ff);
               cur_slot_in = slot_inc(cur_slot_ff);
               state_in = ST_DROP_RD;
            end
         end
         ST_HEAD_RD: state_in = ST_HEAD_EX;
         ST_HEAD_EX: begin
            state_in = ST_EMIT_RD;
            if (!slot_rdata.acked && (age >= timeout_ff)) begin
               state_in = ST_RS_RD;
            end
         end
         ST_RS_RD: begin
            state_in = (cur_ff < next_ff) ? ST_RS_EX : ST_EMIT_RD;
         end
         ST_RS_EX: begin
            if (!slot_rdata.acked) begin
               slot_we = 1'b1;
               slot_wdata.send_time = now_ff;
               buf_we = 1'b1;
               count_in = count_ff + 1'b1;
               resend_in = resend_ff + 1'b1;
            end
            cur_in = cur_ff + 1'b1;
            cur_slot_in = slot_inc(cur_slot_ff);
            state_in = ST_RS_RD;
         end
         ST_EMIT_RD: state_in = ST_EMIT_LD;
         ST_EMIT_LD: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_base_in = base_ff;
               out_sent_in = sent_ff;
               out_acked_in = acked_ff;
               out_resend_in = resend_ff;
               out_rtt_in = rtt_ff;
               out_fin_in = (base_ff >= total_ff);
               if (count_ff == '0) begin
                  out_kind_in = KIND_STATUS;
                  out_seq_in = '0;
                  out_last_in = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  out_kind_in = run_kind_ff;
                  out_seq_in = buf_rdata;
                  out_last_in = (idx_ff + 1'b1 == count_ff);
                  idx_in = idx_ff + 1'b1;
                  state_in = (idx_ff + 1'b1 == count_ff) ? ST_IDLE : ST_EMIT_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         base_ff <= '0;      base_slot_ff <= '0;
         next_ff <= '0;      next_slot_ff <= '0;
         sent_ff <= '0;      acked_ff <= '0;
         resend_ff <= '0;    rtt_ff <= '0;
         out_valid_ff <= 1'b0;
         mode_ff <= 1'b0;
         total_ff <= RESET_TOTAL;
         limit_ff <= RESET_WINDOW;
         timeout_ff <= RESET_TIMEOUT;
      end else begin
         state_ff <= state_in;
         base_ff <= base_in;    base_slot_ff <= base_slot_in;
         next_ff <= next_in;    next_slot_ff <= next_slot_in;
         sent_ff <= sent_in;    acked_ff <= acked_in;
         resend_ff <= resend_in; rtt_ff <= rtt_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_MODE:    mode_ff <= csr_data[0];
               CSR_TOTAL:   total_ff <= csr_data[30:0];
               CSR_WINDOW:  limit_ff <= csr_data[6:0];
               CSR_TIMEOUT: timeout_ff <= csr_data;
               default:     mode_ff <= mode_ff;
            endcase
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      now_ff <= now_in;        ack_ff <= ack_in;
      cur_ff <= cur_in;        cur_slot_ff <= cur_slot_in;
      run_kind_ff <= run_kind_in;
      count_ff <= count_in;    idx_ff <= idx_in;
      out_kind_ff <= out_kind_in;   out_seq_ff <= out_seq_in;
      out_last_ff <= out_last_in;   out_base_ff <= out_base_in;
      out_sent_ff <= out_sent_in;   out_acked_ff <= out_acked_in;
      out_resend_ff <= out_resend_in; out_rtt_ff <= out_rtt_in;
      out_fin_ff <= out_fin_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_result_kind = out_kind_ff;
   assign rsp_packet_sequence = out_seq_ff;
   assign rsp_last_of_run = out_last_ff;
   assign rsp_window_base = out_base_ff;
   assign rsp_sent_count = out_sent_ff;
   assign rsp_acked_count = out_acked_ff;
   assign rsp_resend_count = out_resend_ff;
   assign rsp_rtt_total = out_rtt_ff;
   assign rsp_finished = out_fin_ff;
endmodule

// ===== hdl/swsnd_slot_mem.sv =====
// window slot memory: acked bit and send time, registered read
// depends on swsnd_pkg
`timescale 1ns / 1ps
module swsnd_slot_mem #(
   parameter int DEPTH = 8,
   parameter int AW = 3
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  swsnd_pkg::slot_type wr_data,
   input  logic [AW-1:0]       rd_addr,
   output swsnd_pkg::slot_type rd_data
);
   import swsnd_pkg::*;
   slot_type mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== hdl/swsnd_run_buf.sv =====
// buffer of sequence numbers sent by one request, registered read
// depends on nothing
`timescale 1ns / 1ps
module swsnd_run_buf #(
   parameter int DEPTH = 8,
   parameter int AW = 3
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [30:0]   wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [30:0]   rd_data
);
   logic [30:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== hdl/swsnd_checker.sv =====
// port-level checks of the sliding window sender, bound to the top level
// depends on swsnd_pkg and sliding_window_sender_assert.svh
`timescale 1ns / 1ps
`include "sliding_window_sender_assert.svh"
module swsnd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_result_kind,
   input logic [30:0] rsp_packet_sequence,
   input logic        rsp_last_of_run
);
   import swsnd_pkg::*;
   // a stalled result holds
   `SWSND_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_packet_sequence))
   // a status result stands alone and carries no sequence
   `SWSND_ASSERT_NOW(a_status_last, clock, reset, rsp_valid && (rsp_result_kind == KIND_STATUS), rsp_last_of_run && (rsp_packet_sequence == '0))
   // no undefined result kind is shown
   `SWSND_ASSERT_NOW(a_kind_code, clock, reset, rsp_valid, rsp_result_kind != 2'd3)
   // an accepted request keeps the block busy in the next cycle
   `SWSND_ASSERT_NEXT(a_busy_after, clock, reset, req_valid && !req_stall, req_stall)
endmodule

bind sliding_window_sender swsnd_checker u_swsnd_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_result_kind(rsp_result_kind),
   .rsp_packet_sequence(rsp_packet_sequence), .rsp_last_of_run(rsp_last_of_run)
);

// ===== test/tb.sv =====
// self-checking testbench of the sliding window sender
// depends on swsnd_pkg and sliding_window_sender
`timescale 1ns / 1ps
module tb;
   import swsnd_pkg::*;

   localparam logic [1:0] OP_NONE = 2'd3;     // undefined operation, status only
   localparam int DEPTH = 8;
   localparam int SETTLE = 200;               // cycles after the last result
   localparam longint LIMIT = 400000;

   typedef struct {
      logic [1:0]  op;
      logic [31:0] now;
      logic [7:0]  kind;
      logic [31:0] echo;
      logic [31:0] ackn;
   } request_t;

   typedef struct {
      logic [1:0]  kind;
      logic [30:0] seq;
      logic        last;
      logic [30:0] base;
      logic [31:0] sent;
      logic [31:0] acked;
      logic [31:0] resent;
      logic [47:0] rtt;
      logic        fin;
   } outcome_t;

   logic clock, reset;
   logic req_valid, req_stall;
   logic [1:0] req_operation;
   logic [31:0] req_time_now;
   logic [7:0] req_packet_kind;
   logic signed [31:0] req_echo_sequence, req_ack_sequence;
   logic rsp_valid, rsp_stall;
   logic [1:0] rsp_result_kind;
   logic [30:0] rsp_packet_sequence, rsp_window_base;
   logic rsp_last_of_run, rsp_finished;
   logic [31:0] rsp_sent_count, rsp_acked_count, rsp_resend_count;
   logic [47:0] rsp_rtt_total;
   logic csr_valid, csr_ready;
   logic [1:0] csr_index;
   logic [31:0] csr_data;

   sliding_window_sender u_top (.*);

   // shadow of the sender: registers, sequence numbers, window slots
   logic        sh_mode;
   logic [30:0] sh_total;
   logic [6:0]  sh_window;
   logic [31:0] sh_timeout;
   logic [30:0] sh_base, sh_next;
   bit          sh_acked [DEPTH];
   logic [31:0] sh_sent_at [DEPTH];
   logic [31:0] sh_sent, sh_ackd, sh_resent;
   logic [47:0] sh_rtt;

   request_t pending_reqs[$];
   outcome_t awaited[$];
   request_t cur;
   int idle_pct, stall_pct;
   int errors, n_reqs, n_results;
   longint cycles;
   logic [31:0] clock_us;

   // request channel: hold while stalled, otherwise pull the next pending request
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_request(cur);
            n_reqs++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
               cur = pending_reqs.pop_front();
               req_operation     <= cur.op;
               req_time_now      <= cur.now;
               req_packet_kind   <= cur.kind;
               req_echo_sequence <= cur.echo;
               req_ack_sequence  <= cur.ackn;
               req_valid         <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result channel: check each accepted result against the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) check_result();
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // run-away guard
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles, %0d results still awaited", cycles,
                  awaited.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic report(string what, longint got, longint want);
      $display("mismatch at result %0d: %s got %0h expected %0h", n_results, what,
               got, want);
      errors++;
   endtask

   task automatic check_result();
      outcome_t e;
      if (awaited.size() == 0) begin
         report("unexpected result, kind", rsp_result_kind, 0);
         return;
      end
      e = awaited.pop_front();
      n_results++;
      if (rsp_result_kind !== e.kind) report("result_kind", rsp_result_kind, e.kind);
      if (rsp_packet_sequence !== e.seq)
         report("packet_sequence", rsp_packet_sequence, e.seq);
      if (rsp_last_of_run !== e.last) report("last_of_run", rsp_last_of_run, e.last);
      if (rsp_window_base !== e.base) report("window_base", rsp_window_base, e.base);
      if (rsp_sent_count !== e.sent) report("sent_count", rsp_sent_count, e.sent);
      if (rsp_acked_count !== e.acked) report("acked_count", rsp_acked_count, e.acked);
      if (rsp_resend_count !== e.resent)
         report("resend_count", rsp_resend_count, e.resent);
      if (rsp_rtt_total !== e.rtt) report("rtt_total", rsp_rtt_total, e.rtt);
      if (rsp_finished !== e.fin) report("finished", rsp_finished, e.fin);
   endtask

   // mark one sequence acknowledged and add its round trip, saturating
   task automatic record_ack(logic [31:0] seq, logic [31:0] now);
      logic [31:0] age;
      logic [48:0] sum;
      age = now - sh_sent_at[seq % DEPTH];
      sh_acked[seq % DEPTH] = 1'b1;
      sh_ackd++;
      sum = {1'b0, sh_rtt} + {17'd0, age};
      sh_rtt = (sum > {1'b0, RTT_MAX}) ? RTT_MAX : sum[47:0];
   endtask

   // work out the results of one request and queue them up
   task automatic predict_request(request_t r);
      logic [1:0]  kinds[$];
      logic [30:0] seqs[$];
      logic [31:0] win, s, h;
      outcome_t o;
      win = (sh_window < DEPTH) ? sh_window : DEPTH;
      case (r.op)
         OP_FILL: begin
            while (sh_next < sh_total && {1'b0, sh_next} < {1'b0, sh_base} + win) begin
               sh_acked[sh_next % DEPTH] = 1'b0;
               sh_sent_at[sh_next % DEPTH] = r.now;
               kinds.push_back(KIND_NEW);
               seqs.push_back(sh_next);
               sh_sent++;
               sh_next++;
            end
         end
         OP_PACKET: begin
            if (sh_mode == 1'b0) begin
               // per-packet ack: negative echoes fail the range tests as large values
               if (r.echo < {1'b0, sh_total} && r.echo >= {1'b0, sh_base} &&
                   r.echo < {1'b0, sh_next} && !sh_acked[r.echo % DEPTH]) begin
                  record_ack(r.echo, r.now);
                  while (sh_base < sh_total && sh_base < sh_next && sh_acked[sh_base % DEPTH])
                     sh_base++;
               end
            end else if (r.kind == ACK_KIND && r.ackn >= {1'b0, sh_base} &&
                         r.ackn < {1'b0, sh_total} && r.ackn < {1'b0, sh_next}) begin
               for (s = sh_base; s <= r.ackn; s++)
                  if (!sh_acked[s % DEPTH]) record_ack(s, r.now);
               sh_base = r.ackn[30:0] + 31'd1;
            end
         end
         OP_TIMEOUT: begin
            if (sh_mode == 1'b0) begin
               // drop timed-out heads, skipping over acknowledged slots
               while (sh_base < sh_total && sh_base < sh_next) begin
                  if (!sh_acked[sh_base % DEPTH]) begin
                     if (r.now - sh_sent_at[sh_base % DEPTH] < sh_timeout) break;
                     sh_acked[sh_base % DEPTH] = 1'b1;
                  end
                  sh_base++;
               end
            end else if (sh_base < sh_next) begin
               h = sh_base % DEPTH;
               if (!sh_acked[h] && r.now - sh_sent_at[h] >= sh_timeout) begin
                  for (s = sh_base; s < sh_next; s++)
                     if (!sh_acked[s % DEPTH]) begin
                        kinds.push_back(KIND_RESEND);
                        seqs.push_back(s[30:0]);
                        sh_sent_at[s % DEPTH] = r.now;
                        sh_resent++;
                     end
               end
            end
         end
         default: ;
      endcase
      if (kinds.size() == 0) begin
         kinds.push_back(KIND_STATUS);
         seqs.push_back('0);
      end
      foreach (kinds[k]) begin
         o.kind = kinds[k];
         o.seq = seqs[k];
         o.last = (k == kinds.size() - 1);
         o.base = sh_base;
         o.sent = sh_sent;
         o.acked = sh_ackd;
         o.resent = sh_resent;
         o.rtt = sh_rtt;
         o.fin = (sh_base >= sh_total);
         awaited.push_back(o);
      end
   endtask

   // wait for every request to be taken and answered, then let the block go quiet
   task automatic settle();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_valid || awaited.size() != 0);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_MODE:    sh_mode = value[0];
         CSR_TOTAL:   sh_total = value[30:0];
         CSR_WINDOW:  sh_window = value[6:0];
         CSR_TIMEOUT: sh_timeout = value;
         default: ;
      endcase
   endtask

   task automatic configure(logic mode, logic [30:0] total, logic [6:0] win,
                            logic [31:0] tmo);
      settle();
      write_reg(CSR_MODE, {31'd0, mode});
      write_reg(CSR_TOTAL, {1'b0, total});
      write_reg(CSR_WINDOW, {25'd0, win});
      write_reg(CSR_TIMEOUT, tmo);
   endtask

   // directed request, answered in full before the next one is built
   task automatic send_one(logic [1:0] op, logic [31:0] now, logic [7:0] kind,
                           logic [31:0] echo, logic [31:0] ackn);
      request_t r;
      r = '{op, now, kind, echo, ackn};
      pending_reqs.push_back(r);
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_valid || awaited.size() != 0);
   endtask

   // random traffic, built in short bursts around the current window
   task automatic random_traffic(int count);
      request_t r;
      int pick, span;
      for (int n = 0; n < count; n++) begin
         if (n % 4 == 0)
            while (pending_reqs.size() != 0) @(negedge clock);
         clock_us += $urandom_range(0, 40);
         if ($urandom_range(9) == 0) clock_us += sh_timeout;
         span = sh_next - sh_base + 1;
         pick = $urandom_range(99);
         r.now  = clock_us;
         r.kind = ($urandom_range(9) == 0) ? 8'($urandom) : ACK_KIND;
         r.echo = sh_base + $urandom_range(0, span);
         r.ackn = sh_base + $urandom_range(0, span);
         if (pick < 30) r.op = OP_FILL;
         else if (pick < 75) r.op = OP_PACKET;
         else if (pick < 95) r.op = OP_TIMEOUT;
         else begin
            // noise: any operation, any field value
            r.op = 2'($urandom);
            r.now = $urandom;
            r.kind = 8'($urandom);
            r.echo = $urandom;
            r.ackn = $urandom;
         end
         pending_reqs.push_back(r);
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = OP_FILL;
      req_time_now = '0;
      req_packet_kind = '0;
      req_echo_sequence = '0;
      req_ack_sequence = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_MODE;
      csr_data = '0;
      idle_pct = 0;
      stall_pct = 0;
      errors = 0;
      n_reqs = 0;
      n_results = 0;
      cycles = 0;
      sh_mode = 1'b0;
      sh_total = RESET_TOTAL;
      sh_window = RESET_WINDOW;
      sh_timeout = RESET_TIMEOUT;
      sh_base = '0;
      sh_next = '0;
      sh_sent = '0;
      sh_ackd = '0;
      sh_resent = '0;
      sh_rtt = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // a first fill under the reset defaults
      send_one(OP_FILL, 32'd10, 8'd0, 32'd0, 32'd0);

      // per-packet acks: out of order, duplicate, negative, beyond next, head drops
      configure(1'b0, 31'd40, 7'd8, 32'd100);
      send_one(OP_PACKET, 32'd50, ACK_KIND, {1'b0, sh_base}, 32'd0);
      send_one(OP_PACKET, 32'd60, 8'd0, {1'b0, sh_base} + 32'd2, 32'd0);
      send_one(OP_PACKET, 32'd61, 8'd0, {1'b0, sh_base} + 32'd2, 32'd0);
      send_one(OP_PACKET, 32'd62, 8'd0, 32'hFFFF_FFFF, 32'd0);
      send_one(OP_PACKET, 32'd63, 8'd0, {1'b0, sh_next}, 32'd0);
      send_one(OP_PACKET, 32'd64, 8'd0, 32'h7FFF_FFFF, 32'd0);
      send_one(OP_TIMEOUT, 32'd70, 8'd0, 32'd0, 32'd0);
      send_one(OP_TIMEOUT, 32'd500, 8'd0, 32'd0, 32'd0);
      send_one(OP_FILL, 32'd510, 8'd0, 32'd0, 32'd0);
      send_one(OP_NONE, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

      // cumulative acks, widest window, largest total, timeout of one
      configure(1'b1, 31'h7FFF_FFFF, 7'd64, 32'd1);
      send_one(OP_FILL, 32'd1000, 8'd0, 32'd0, 32'd0);
      send_one(OP_PACKET, 32'd1010, 8'd1, 32'd0, {1'b0, sh_base} + 32'd1);
      send_one(OP_PACKET, 32'd1020, ACK_KIND, 32'd0, {1'b0, sh_base} + 32'd2);
      send_one(OP_PACKET, 32'd1021, ACK_KIND, 32'd0, 32'h8000_0000);
      send_one(OP_PACKET, 32'd1022, ACK_KIND, 32'd0, 32'h7FFF_FFFF);
      send_one(OP_PACKET, 32'd1023, ACK_KIND, 32'd0, {1'b0, sh_base} - 32'd1);
      send_one(OP_TIMEOUT, 32'd1030, 8'd0, 32'd0, 32'd0);
      send_one(OP_TIMEOUT, 32'hFFFF_FFFF, 8'd0, 32'd0, 32'd0);
      send_one(OP_PACKET, 32'd5, ACK_KIND, 32'd0, {1'b0, sh_next} - 32'd1);

      // random phases: each changes the registers, the later ones also the idling pattern
      clock_us = 32'd2000;
      configure(1'b0, sh_base + 31'd40, 7'd3, 32'd30);
      random_traffic(18);

      configure(1'b1, sh_base + 31'd40, 7'd8, 32'd60);
      idle_pct = 85;
      random_traffic(18);

      clock_us = 32'hFFFF_FF00;   // round trips across the time wrap
      configure(1'b0, sh_base + 31'd25, 7'd1, 32'd0);
      idle_pct = 0;
      stall_pct = 85;
      random_traffic(18);

      configure(1'b1, sh_base + 31'd50, 7'd64, 32'hFFFF_FFFF);
      idle_pct = 35;
      stall_pct = 35;
      random_traffic(18);

      // zero window sends nothing; then shrink the total below what is in flight
      configure(1'b0, sh_base + 31'd30, 7'd0, 32'd20);
      random_traffic(6);
      configure(1'b0, sh_base + 31'd30, 7'd8, 32'd20);
      idle_pct = 0;
      stall_pct = 0;
      random_traffic(8);
      configure(1'b1, sh_base + 31'd3, 7'd8, 32'd20);
      random_traffic(12);

      settle();
      $display("covered %0d requests and %0d results in both ack modes,", n_reqs,
               n_results);
      $display("windows 0 to 64, shrinking totals, time wrap and four idling patterns");
      if (errors == 0 && awaited.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches, %0d results never came", errors, awaited.size());
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
